>>> rtl/core/ftps_pkg.sv
// ----------------------------------------------------------------------------
// ftps_pkg
// Shared types, codes and constants of the framed tile panel shader.
// ----------------------------------------------------------------------------
package ftps_pkg;

  localparam int TILE_SIZE = 64;
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 32;
  localparam int PAL_AW    = 8;
  localparam int TEXEL_W   = 8;
  localparam int SCALE_W   = 5;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  // Reciprocal multiply: floor(v / s) == (v * recip_lut(s)) >> RECIP_SHIFT
  // for every 12-bit v and scale 1..31.
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = COORD_W + RECIP_W;

  // Signed width of the frame bounds and strip edges.
  localparam int BND_W = 16;

  localparam logic [SCALE_W-1:0] SCALE_RST  = 5'd1;
  localparam logic [SIZE_W-1:0]  BORDER_RST = 6'd8;
  localparam logic [SIZE_W-1:0]  CAPTION_RST = 6'd16;

  localparam logic [7:0] TONE_MID_VAL = 8'd192;
  localparam logic [7:0] TONE_HI_VAL  = 8'd255;
  localparam logic [7:0] TONE_LO_VAL  = 8'd128;

  typedef enum logic [1:0] {
    OP_LOAD_TEXEL   = 2'd0,
    OP_LOAD_PALETTE = 2'd1,
    OP_SHADE        = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PANEL_X      = 3'd0,
    CFG_PANEL_Y      = 3'd1,
    CFG_PANEL_WIDTH  = 3'd2,
    CFG_PANEL_HEIGHT = 3'd3,
    CFG_SCALE        = 3'd4,
    CFG_BORDER_SIZE  = 3'd5,
    CFG_CAPTION_SIZE = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TONE_MID = 2'd0,
    TONE_HI  = 2'd1,
    TONE_LO  = 2'd2
  } tone_t;

  // ceil(2^17 / s); scale zero behaves as scale one.
  function automatic logic [RECIP_W-1:0] recip_lut(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    case (s)
      5'd0:    r = 18'd131072;
      5'd1:    r = 18'd131072;
      5'd2:    r = 18'd65536;
      5'd3:    r = 18'd43691;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd26215;
      5'd6:    r = 18'd21846;
      5'd7:    r = 18'd18725;
      5'd8:    r = 18'd16384;
      5'd9:    r = 18'd14564;
      5'd10:   r = 18'd13108;
      5'd11:   r = 18'd11916;
      5'd12:   r = 18'd10923;
      5'd13:   r = 18'd10083;
      5'd14:   r = 18'd9363;
      5'd15:   r = 18'd8739;
      5'd16:   r = 18'd8192;
      5'd17:   r = 18'd7711;
      5'd18:   r = 18'd7282;
      5'd19:   r = 18'd6899;
      5'd20:   r = 18'd6554;
      5'd21:   r = 18'd6242;
      5'd22:   r = 18'd5958;
      5'd23:   r = 18'd5699;
      5'd24:   r = 18'd5462;
      5'd25:   r = 18'd5243;
      5'd26:   r = 18'd5042;
      5'd27:   r = 18'd4855;
      5'd28:   r = 18'd4682;
      5'd29:   r = 18'd4520;
      5'd30:   r = 18'd4370;
      default: r = 18'd4229;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tone_value(input tone_t t);
    logic [7:0] v;
    case (t)
      TONE_HI: v = TONE_HI_VAL;
      TONE_LO: v = TONE_LO_VAL;
      default: v = TONE_MID_VAL;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/framed_tile_panel_shader_core.sv
// Throughput: one request per cycle while out_stall is low; five register
// stages (input, reciprocal multiply and frame bounds, strip compare and
// tile read, palette read, tone).
// Load requests pass the same stages and write their store in request order.
// Reset (sync, rst_n low) empties the pipeline and loads the register reset
// values; tile and palette memories are not cleared.
// ----------------------------------------------------------------------------
// framed_tile_panel_shader_core
// Shades pixels of a bevel-framed panel from a tile texture and palette.
// ----------------------------------------------------------------------------
module framed_tile_panel_shader_core #(
  parameter int TILE_SIZE = ftps_pkg::TILE_SIZE
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [ftps_pkg::COORD_W-1:0]    in_px,
  input  logic [ftps_pkg::COORD_W-1:0]    in_py,
  input  logic [ftps_pkg::COORD_W-1:0]    in_load_index,
  input  logic [ftps_pkg::COLOR_W-1:0]    in_load_value,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ftps_pkg::COLOR_W-1:0]    out_color,
  output logic                            out_covered,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TILE_W  = $clog2(TILE_SIZE);
  localparam int TILE_AW = 2 * TILE_W;
  localparam int CW      = ftps_pkg::COORD_W;
  localparam int BW      = ftps_pkg::BND_W;
  localparam int PW      = ftps_pkg::PROD_W;
  localparam int SH      = ftps_pkg::RECIP_SHIFT;

  // ---------------- configuration ----------------
  logic [CW-1:0]                    panel_x_r, panel_y_r, panel_w_r, panel_h_r;
  logic [ftps_pkg::SCALE_W-1:0]     scale_r;
  logic [ftps_pkg::SIZE_W-1:0]      border_r, caption_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_x_r <= '0;
      panel_y_r <= '0;
      panel_w_r <= '0;
      panel_h_r <= '0;
      scale_r   <= ftps_pkg::SCALE_RST;
      border_r  <= ftps_pkg::BORDER_RST;
      caption_r <= ftps_pkg::CAPTION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ftps_pkg::cfg_idx_t'(cfg_index))
        ftps_pkg::CFG_PANEL_X:      panel_x_r <= cfg_data;
        ftps_pkg::CFG_PANEL_Y:      panel_y_r <= cfg_data;
        ftps_pkg::CFG_PANEL_WIDTH:  panel_w_r <= cfg_data;
        ftps_pkg::CFG_PANEL_HEIGHT: panel_h_r <= cfg_data;
        ftps_pkg::CFG_SCALE:        scale_r   <= cfg_data[ftps_pkg::SCALE_W-1:0];
        ftps_pkg::CFG_BORDER_SIZE:  border_r  <= cfg_data[ftps_pkg::SIZE_W-1:0];
        ftps_pkg::CFG_CAPTION_SIZE: caption_r <= cfg_data[ftps_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage enables ----------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_valid_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  // ---------------- stage 1: input ----------------
  logic [1:0]                  op1_r;
  logic [CW-1:0]               x1_r, y1_r, li1_r;
  logic [ftps_pkg::COLOR_W-1:0] lv1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r <= in_opcode;
      x1_r  <= in_px;
      y1_r  <= in_py;
      li1_r <= in_load_index;
      lv1_r <= in_load_value;
    end
  end

  // ---------------- stage 2: divide by scale, frame bounds ----------------
  logic [ftps_pkg::SCALE_W-1:0] s_eff;
  logic [ftps_pkg::RECIP_W-1:0] recip;
  logic [PW-1:0]                prodx_nxt, prody_nxt;
  logic [10:0]                  bs;
  logic [6:0]                   bc;
  logic [11:0]                  bcs;
  logic signed [BW-1:0]         x0_nxt, x1b_nxt, y0_nxt, y1b_nxt;

  always_comb begin
    s_eff     = (scale_r == '0) ? ftps_pkg::SCALE_RST : scale_r;
    recip     = ftps_pkg::recip_lut(scale_r);
    prodx_nxt = PW'(x1_r) * PW'(recip);
    prody_nxt = PW'(y1_r) * PW'(recip);
    bs        = 11'(border_r) * 11'(s_eff);
    bc        = 7'(border_r) + 7'(caption_r);
    bcs       = 12'(bc) * 12'(s_eff);
    x0_nxt    = BW'(panel_x_r) - BW'(bs);
    x1b_nxt   = x0_nxt + BW'(panel_w_r) + BW'({bs, 1'b0});
    y0_nxt    = BW'(panel_y_r) - BW'(bcs);
    y1b_nxt   = y0_nxt + BW'(panel_h_r) + BW'(bs) + BW'(bcs);
  end

  logic [1:0]                   op2_r;
  logic [CW-1:0]                x2_r, y2_r, li2_r;
  logic [ftps_pkg::COLOR_W-1:0] lv2_r;
  logic [PW-1:0]                prodx_r, prody_r;
  logic signed [BW-1:0]         x0_r, x1b_r, y0_r, y1b_r;
  logic [ftps_pkg::SCALE_W-1:0] s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2_r   <= op1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      li2_r   <= li1_r;
      lv2_r   <= lv1_r;
      prodx_r <= prodx_nxt;
      prody_r <= prody_nxt;
      x0_r    <= x0_nxt;
      x1b_r   <= x1b_nxt;
      y0_r    <= y0_nxt;
      y1b_r   <= y1b_nxt;
      s2_r    <= s_eff;
    end
  end

  // ---------------- stage 3: strips, tile memory ----------------
  function automatic logic span(input logic signed [BW-1:0] v,
                                input logic signed [BW-1:0] lo,
                                input logic signed [BW-1:0] hi);
    return (v >= lo) && (v < hi);
  endfunction

  logic signed [BW-1:0] xs, ys, sv, s2v, s3v, s12v, s13v;
  logic                 cov_nxt;
  ftps_pkg::tone_t      tone_nxt;
  logic [TILE_AW-1:0]   tile_addr;

  always_comb begin
    xs   = BW'(x2_r);
    ys   = BW'(y2_r);
    sv   = BW'(s2_r);
    s2v  = sv <<< 1;
    s3v  = sv + s2v;
    s12v = (sv <<< 3) + (sv <<< 2);
    s13v = s12v + sv;
    cov_nxt = span(xs, x0_r, x1b_r) && span(ys, y0_r, y1b_r);
    // last strip in draw order wins
    if (span(ys, y0_r + s13v, y1b_r - s2v) && span(xs, x1b_r - s3v, x1b_r - s2v))
      tone_nxt = ftps_pkg::TONE_HI;
    else if (span(ys, y0_r + sv, y1b_r - sv) && span(xs, x1b_r - sv, x1b_r))
      tone_nxt = ftps_pkg::TONE_LO;
    else if (span(ys, y0_r + s13v, y1b_r - s2v) && span(xs, x0_r + s2v, x0_r + s3v))
      tone_nxt = ftps_pkg::TONE_LO;
    else if (span(ys, y0_r + sv, y1b_r - sv) && span(xs, x0_r, x0_r + sv))
      tone_nxt = ftps_pkg::TONE_HI;
    else if (span(ys, y1b_r - s3v, y1b_r - s2v) && span(xs, x0_r + s2v, x1b_r - s2v))
      tone_nxt = ftps_pkg::TONE_HI;
    else if (span(ys, y1b_r - sv, y1b_r) && span(xs, x0_r, x1b_r))
      tone_nxt = ftps_pkg::TONE_LO;
    else if (span(ys, y0_r + s12v, y0_r + s13v) && span(xs, x0_r + s2v, x1b_r - s2v))
      tone_nxt = ftps_pkg::TONE_LO;
    else if (span(ys, y0_r, y0_r + sv) && span(xs, x0_r, x1b_r))
      tone_nxt = ftps_pkg::TONE_HI;
    else
      tone_nxt = ftps_pkg::TONE_MID;
    tile_addr = {prody_r[SH +: TILE_W], prodx_r[SH +: TILE_W]};
  end

  logic [ftps_pkg::TEXEL_W-1:0] tile_mem [TILE_SIZE*TILE_SIZE];
  logic [ftps_pkg::TEXEL_W-1:0] tile_q_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      if (v2_r && op2_r == ftps_pkg::OP_LOAD_TEXEL) begin
        tile_mem[li2_r[TILE_AW-1:0]] <= lv2_r[ftps_pkg::TEXEL_W-1:0];
      end
      tile_q_r <= tile_mem[tile_addr];
    end
  end

  logic [1:0]                   op3_r;
  logic [CW-1:0]                li3_r;
  logic [ftps_pkg::COLOR_W-1:0] lv3_r;
  logic                         cov3_r;
  ftps_pkg::tone_t              tone3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      op3_r   <= op2_r;
      li3_r   <= li2_r;
      lv3_r   <= lv2_r;
      cov3_r  <= cov_nxt;
      tone3_r <= tone_nxt;
    end
  end

  // ---------------- stage 4: palette memory ----------------
  logic [ftps_pkg::COLOR_W-1:0] pal_mem [2**ftps_pkg::PAL_AW];
  logic [ftps_pkg::COLOR_W-1:0] pal_q_r;
  logic                         pal_wr;

  assign pal_wr = v3_r && op3_r == ftps_pkg::OP_LOAD_PALETTE
                  && li3_r[CW-1:ftps_pkg::PAL_AW] == '0;

  always_ff @(posedge clk) begin
    if (en4) begin
      if (pal_wr) begin
        pal_mem[li3_r[ftps_pkg::PAL_AW-1:0]] <= lv3_r;
      end
      pal_q_r <= pal_mem[tile_q_r];
    end
  end

  logic [1:0]      op4_r;
  logic            cov4_r;
  ftps_pkg::tone_t tone4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      op4_r   <= op3_r;
      cov4_r  <= cov3_r;
      tone4_r <= tone3_r;
    end
  end

  // ---------------- stage 5: tone and output ----------------
  logic [7:0]                   tone_val;
  logic [15:0]                  prod0, prod1, prod2;
  logic [ftps_pkg::COLOR_W-1:0] color_nxt;
  logic [ftps_pkg::COLOR_W-1:0] color_r;
  logic                         covered_r;
  logic                         shade4;

  always_comb begin
    tone_val  = ftps_pkg::tone_value(tone4_r);
    prod0     = 16'(pal_q_r[7:0])   * 16'(tone_val);
    prod1     = 16'(pal_q_r[15:8])  * 16'(tone_val);
    prod2     = 16'(pal_q_r[23:16]) * 16'(tone_val);
    color_nxt = cov4_r ? {pal_q_r[31:24], prod2[15:8], prod1[15:8], prod0[15:8]} : '0;
  end

  assign shade4 = v4_r && op4_r == ftps_pkg::OP_SHADE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en5) begin
      out_valid_r <= shade4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      color_r   <= color_nxt;
      covered_r <= cov4_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_color   = color_r;
  assign out_covered = covered_r;

  // ---------------- assertions ----------------
  a_uncovered_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !covered_r |-> color_r == '0)
    else $error("uncovered pixel with nonzero color");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with empty first stage");

  a_out_from_shade: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(shade4))
    else $error("result without a shade request");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && v4_r |=> v4_r && $stable(tone4_r) && $stable(pal_q_r))
    else $error("stage 4 lost under output stall");

endmodule
